// ===== hdl/bf_pkg.sv =====
// ----------------------------------------------------------------------------
// bf_pkg
// shared types, codes and defaults for the shortest path engine
// ----------------------------------------------------------------------------
package bf_pkg;

   localparam int DEF_MAX_VERTICES = 256;
   localparam int DEF_MAX_EDGES    = 1024;

   localparam logic [8:0] VC_RESET = 9'd256;

   // command codes carried on the request side
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_RUN   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // status codes carried on the response side
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_NEG_CYCLE  = 2'd2,
      ST_UNREACHED  = 2'd3
   } status_type;

   typedef logic [7:0] vertex_type;

   typedef struct packed {
      logic signed [15:0] weight;
      vertex_type         head;
      vertex_type         tail;
   } edge_type;

   // one write into the distance store
   typedef struct packed {
      logic               en;
      vertex_type         addr;
      logic signed [31:0] data;
   } dist_wr_type;

endpackage

// ===== hdl/bf_edge_store.sv =====
// ----------------------------------------------------------------------------
// bf_edge_store
// edge memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module bf_edge_store #(
   parameter int DEPTH = bf_pkg::DEF_MAX_EDGES,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  bf_pkg::edge_type  wr_data,
   input  logic [AW-1:0]     rd_addr,
   output bf_pkg::edge_type  rd_data
);

   bf_pkg::edge_type mem [DEPTH];
   bf_pkg::edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bf_dist_store.sv =====
// ----------------------------------------------------------------------------
// bf_dist_store
// distance memory, one write port, two registered read ports
// ----------------------------------------------------------------------------
module bf_dist_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic [AW-1:0]      rd_addr_a,
   output logic signed [31:0] rd_data_a,
   input  logic [AW-1:0]      rd_addr_b,
   output logic signed [31:0] rd_data_b
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_a_ff;
   logic signed [31:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hdl/bf_relax_unit.sv =====
// ----------------------------------------------------------------------------
// bf_relax_unit
// relaxes one edge: forwarding, saturating add, compare, write request
// ----------------------------------------------------------------------------
module bf_relax_unit #(
   parameter int REACH_N = 256,
   parameter int RW      = 8
) (
   input  logic                 valid,
   input  bf_pkg::edge_type     edge_in,
   input  logic signed [31:0]   rd_tail,
   input  logic signed [31:0]   rd_head,
   input  bf_pkg::dist_wr_type  fwd,
   input  logic [REACH_N-1:0]   marks,
   input  logic [8:0]           n_lim,
   output bf_pkg::dist_wr_type  wr
);

   logic signed [31:0] du;
   logic signed [31:0] dv;
   logic        [32:0] sum;
   logic signed [31:0] cand;
   logic               in_range;
   logic               mu;
   logic               mv;

   always_comb begin
      // last cycle's write has not reached the read data yet
      du = (fwd.en && fwd.addr == edge_in.tail) ? fwd.data : rd_tail;
      dv = (fwd.en && fwd.addr == edge_in.head) ? fwd.data : rd_head;

      sum = {du[31], du} + {{17{edge_in.weight[15]}}, edge_in.weight};
      if (sum[32] != sum[31]) begin
         cand = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         cand = sum[31:0];
      end

      in_range = ({1'b0, edge_in.tail} < n_lim) && ({1'b0, edge_in.head} < n_lim);
      mu = in_range && marks[edge_in.tail[RW-1:0]];
      mv = in_range && marks[edge_in.head[RW-1:0]];

      wr.en   = valid && in_range && mu && (!mv || cand < dv);
      wr.addr = edge_in.head;
      wr.data = cand;
   end

endmodule

// ===== hdl/bellman_ford_shortest_paths.sv =====
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths
// single source shortest paths over a stored edge list, with early stop
// and a negative cycle check pass
// ----------------------------------------------------------------------------
//
// channel   direction  tdata (low bit up)                     tuser
// req_*     in         from_vertex, to_vertex, weight          cmd
// rsp_*     out        distance, passes, zero pad (48 bits)    status
// csr_*     in         vertex_count, write only                -
//
// clear and add give their result the cycle after the transfer; read goes
// through the S_READ state, where the registered distance memory read
// returns, before its response is registered
// a run makes P main passes and one check pass over the stored edges; the
// single edge store read port walks one edge a cycle, and the pipe drains
// at the end of every pass
// one command is in flight at a time; a stalled response holds the block
// reset is synchronous and active high; memories hold no reset content
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths #(
   parameter int MAX_VERTICES = bf_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = bf_pkg::DEF_MAX_EDGES
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // from_vertex[7:0], to_vertex[15:8], weight[31:16]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // distance[31:0], passes[40:32], zero[47:41]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // configuration
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data  // vertex_count
);

   // vertices that a command can name, bounded by the 8-bit vertex fields
   localparam int REACH_N   = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
   localparam int RW        = $clog2(REACH_N);
   localparam int EW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW       = $clog2(MAX_EDGES + 1);
   localparam int N_CLAMP   = (MAX_VERTICES < 511) ? MAX_VERTICES : 511;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_PASS
   } state_type;

   // control and result registers
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bf_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic signed [31:0]     rsp_dist_ff, rsp_dist_in;
   logic [8:0]             rsp_passes_ff, rsp_passes_in;
   logic [ECW-1:0]         edge_total_ff, edge_total_in;
   logic [REACH_N-1:0]     marks_ff, marks_in;
   logic                   cycle_ff, cycle_in;
   logic [8:0]             passes_ff, passes_in;
   logic [8:0]             vc_ff, vc_in;
   bf_pkg::status_type     read_status_ff, read_status_in;

   // pass walker
   logic [ECW-1:0]         k_ff, k_in;
   logic                   b_valid_ff, b_valid_in;
   logic                   c_valid_ff, c_valid_in;
   bf_pkg::edge_type       c_edge_ff, c_edge_in;
   logic                   changed_ff, changed_in;
   logic                   check_ff, check_in;
   logic [8:0]             pass_ff, pass_in;
   bf_pkg::dist_wr_type    fwd_ff, fwd_in;

   // datapath
   logic                   req_accept;
   logic                   rsp_accept;
   bf_pkg::cmd_type        cmd;
   bf_pkg::vertex_type     req_from;
   bf_pkg::vertex_type     req_to;
   logic signed [15:0]     req_weight;
   logic [8:0]             n_lim;
   logic                   full;
   logic                   edge_we;
   bf_pkg::edge_type       edge_wdata;
   bf_pkg::edge_type       edge_rdata;
   bf_pkg::dist_wr_type    dist_wr;
   bf_pkg::dist_wr_type    relax_wr;
   logic [RW-1:0]          dist_rd_a_addr;
   logic signed [31:0]     dist_rd_a;
   logic signed [31:0]     dist_rd_b;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;

   assign cmd        = bf_pkg::cmd_type'(req_tuser);
   assign req_from   = req_tdata[7:0];
   assign req_to     = req_tdata[15:8];
   assign req_weight = req_tdata[31:16];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_passes_ff, rsp_dist_ff};
   assign rsp_tuser  = rsp_status_ff;

   // vertices in use, clamped to 1 .. MAX_VERTICES
   always_comb begin
      if (vc_ff == 9'd0) begin
         n_lim = 9'd1;
      end else if (32'(vc_ff) > MAX_VERTICES) begin
         n_lim = 9'(N_CLAMP);
      end else begin
         n_lim = vc_ff;
      end
   end

   assign full = (edge_total_ff == ECW'(MAX_EDGES));

   assign edge_wdata.tail   = req_from;
   assign edge_wdata.head   = req_to;
   assign edge_wdata.weight = req_weight;

   // edge list memory, read one edge per cycle during a pass
   bf_edge_store #(
      .DEPTH (MAX_EDGES),
      .AW    (EW)
   ) u_edge_store (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_total_ff[EW-1:0]),
      .wr_data (edge_wdata),
      .rd_addr (k_ff[EW-1:0]),
      .rd_data (edge_rdata)
   );

   // port a serves read commands while idle and edge tails during a pass
   assign dist_rd_a_addr = (state_ff == S_IDLE) ? req_from[RW-1:0] : edge_rdata.tail[RW-1:0];

   bf_dist_store #(
      .DEPTH (REACH_N),
      .AW    (RW)
   ) u_dist_store (
      .clock     (clock),
      .wr_en     (dist_wr.en),
      .wr_addr   (dist_wr.addr[RW-1:0]),
      .wr_data   (dist_wr.data),
      .rd_addr_a (dist_rd_a_addr),
      .rd_data_a (dist_rd_a),
      .rd_addr_b (edge_rdata.head[RW-1:0]),
      .rd_data_b (dist_rd_b)
   );

   // relaxation stage, one edge per cycle once the distances are back
   bf_relax_unit #(
      .REACH_N (REACH_N),
      .RW      (RW)
   ) u_relax (
      .valid   (c_valid_ff),
      .edge_in (c_edge_ff),
      .rd_tail (dist_rd_a),
      .rd_head (dist_rd_b),
      .fwd     (fwd_ff),
      .marks   (marks_ff),
      .n_lim   (n_lim),
      .wr      (relax_wr)
   );

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_accept;
      rsp_status_in  = rsp_status_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_passes_in  = rsp_passes_ff;
      edge_total_in  = edge_total_ff;
      marks_in       = marks_ff;
      cycle_in       = cycle_ff;
      passes_in      = passes_ff;
      vc_in          = csr_wr_en ? csr_wr_data : vc_ff;
      read_status_in = read_status_ff;
      k_in           = k_ff;
      b_valid_in     = 1'b0;
      c_valid_in     = b_valid_ff;
      c_edge_in      = edge_rdata;
      changed_in     = changed_ff;
      check_in       = check_ff;
      pass_in        = pass_ff;
      edge_we        = 1'b0;
      dist_wr        = relax_wr;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (cmd)
                  bf_pkg::CMD_CLEAR: begin
                     edge_total_in = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = bf_pkg::ST_OK;
                     rsp_dist_in   = '0;
                     rsp_passes_in = passes_ff;
                  end
                  bf_pkg::CMD_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_dist_in   = '0;
                     rsp_passes_in = passes_ff;
                     if (full) begin
                        rsp_status_in = bf_pkg::ST_FULL;
                     end else begin
                        edge_we       = 1'b1;
                        edge_total_in = edge_total_ff + ECW'(1);
                        rsp_status_in = bf_pkg::ST_OK;
                     end
                  end
                  bf_pkg::CMD_RUN: begin
                     marks_in = '0;
                     cycle_in = 1'b0;
                     if ({1'b0, req_from} < n_lim) begin
                        // seed the source, then the first pass
                        marks_in[req_from[RW-1:0]] = 1'b1;
                        dist_wr.en   = 1'b1;
                        dist_wr.addr = req_from;
                        dist_wr.data = '0;
                        k_in         = '0;
                        changed_in   = 1'b0;
                        if (n_lim > 9'd1) begin
                           pass_in  = 9'd1;
                           check_in = 1'b0;
                        end else begin
                           pass_in  = 9'd0;
                           check_in = 1'b1;
                        end
                        state_in = S_PASS;
                     end else begin
                        passes_in     = '0;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bf_pkg::ST_OK;
                        rsp_dist_in   = '0;
                        rsp_passes_in = '0;
                     end
                  end
                  bf_pkg::CMD_READ: begin
                     if ((32'(req_from) < MAX_VERTICES) && marks_ff[req_from[RW-1:0]]) begin
                        read_status_in = cycle_ff ? bf_pkg::ST_NEG_CYCLE : bf_pkg::ST_OK;
                     end else begin
                        read_status_in = bf_pkg::ST_UNREACHED;
                     end
                     state_in = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = read_status_ff;
            rsp_dist_in   = (read_status_ff == bf_pkg::ST_UNREACHED) ? 32'sd0 : dist_rd_a;
            rsp_passes_in = passes_ff;
            state_in      = S_IDLE;
         end

         S_PASS: begin
            // issue the next edge read
            if (k_ff < edge_total_ff) begin
               b_valid_in = 1'b1;
               k_in       = k_ff + ECW'(1);
            end
            if (relax_wr.en) begin
               changed_in                    = 1'b1;
               marks_in[relax_wr.addr[RW-1:0]] = 1'b1;
            end
            // pass over once every edge has left the pipe
            if (k_ff == edge_total_ff && !b_valid_ff && !c_valid_ff) begin
               if (check_ff) begin
                  cycle_in      = changed_ff;
                  passes_in     = pass_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = changed_ff ? bf_pkg::ST_NEG_CYCLE : bf_pkg::ST_OK;
                  rsp_dist_in   = '0;
                  rsp_passes_in = pass_ff;
                  state_in      = S_IDLE;
               end else begin
                  k_in       = '0;
                  changed_in = 1'b0;
                  if (!changed_ff || !(({1'b0, pass_ff} + 10'd1) < {1'b0, n_lim})) begin
                     check_in = 1'b1;
                  end else begin
                     pass_in = pass_ff + 9'd1;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      fwd_in = dist_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         edge_total_ff  <= '0;
         marks_ff       <= '0;
         cycle_ff       <= 1'b0;
         passes_ff      <= '0;
         vc_ff          <= bf_pkg::VC_RESET;
         k_ff           <= '0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         changed_ff     <= 1'b0;
         check_ff       <= 1'b0;
         pass_ff        <= '0;
         fwd_ff.en      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         edge_total_ff  <= edge_total_in;
         marks_ff       <= marks_in;
         cycle_ff       <= cycle_in;
         passes_ff      <= passes_in;
         vc_ff          <= vc_in;
         k_ff           <= k_in;
         b_valid_ff     <= b_valid_in;
         c_valid_ff     <= c_valid_in;
         changed_ff     <= changed_in;
         check_ff       <= check_in;
         pass_ff        <= pass_in;
         fwd_ff.en      <= fwd_in.en;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_passes_ff  <= rsp_passes_in;
      read_status_ff <= read_status_in;
      c_edge_ff      <= c_edge_in;
      fwd_ff.addr    <= fwd_in.addr;
      fwd_ff.data    <= fwd_in.data;
   end

endmodule
